FILE: design/multichannel_sliding_median_filter_macros.svh
// assertion macros for the sliding median filter
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef MULTICHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define MSMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be seen
`define MSMF_ASSERT_NEVER(lbl, cond, msg) `MSMF_ASSERT(lbl, !(cond), msg)
`else
`define MSMF_ASSERT(lbl, prop, msg)
`define MSMF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: design/msmf_pkg.sv
// shared types and constants of the sliding median filter
// holds the field widths, the sequencer step codes and the microcode table
`default_nettype none

package msmf_pkg;

  // transaction field widths
  localparam int unsigned CH_W  = 2;
  localparam int unsigned SMP_W = 16;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SMP_W-1:0] smp_t;

  // sequencer step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_WRITE  = 3'd1;
  localparam step_t STEP_READ   = 3'd2;
  localparam step_t STEP_LOAD   = 3'd3;
  localparam step_t STEP_SELECT = 3'd4;
  localparam step_t STEP_ZERO   = 3'd5;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ACCEPT   = 3'd1,
    COND_BAD_CH   = 3'd2,
    COND_LAST     = 3'd3,
    COND_OUT_FREE = 3'd4
  } cond_e;

  // one control word
  typedef struct packed {
    logic  in_ready;
    logic  wr_en;
    logic  rd_issue;
    logic  load;
    logic  sel_median;
    logic  sel_zero;
    cond_e cond;
    step_t jump;
    step_t fall;
  } ucode_t;

  // microcode table: jump taken when cond holds, else fall
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t uc;
    uc = '{in_ready: 1'b0, wr_en: 1'b0, rd_issue: 1'b0, load: 1'b0,
           sel_median: 1'b0, sel_zero: 1'b0, cond: COND_NEVER,
           jump: STEP_IDLE, fall: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        uc.in_ready = 1'b1;
        uc.cond     = COND_ACCEPT;
        uc.jump     = STEP_WRITE;
        uc.fall     = STEP_IDLE;
      end
      STEP_WRITE: begin
        uc.wr_en = 1'b1;
        uc.cond  = COND_BAD_CH;
        uc.jump  = STEP_ZERO;
        uc.fall  = STEP_READ;
      end
      STEP_READ: begin
        uc.rd_issue = 1'b1;
        uc.fall     = STEP_LOAD;
      end
      STEP_LOAD: begin
        uc.rd_issue = 1'b1;
        uc.load     = 1'b1;
        uc.cond     = COND_LAST;
        uc.jump     = STEP_SELECT;
        uc.fall     = STEP_LOAD;
      end
      STEP_SELECT: begin
        uc.sel_median = 1'b1;
        uc.cond       = COND_OUT_FREE;
        uc.jump       = STEP_IDLE;
        uc.fall       = STEP_SELECT;
      end
      STEP_ZERO: begin
        uc.sel_zero = 1'b1;
        uc.cond     = COND_OUT_FREE;
        uc.jump     = STEP_IDLE;
        uc.fall     = STEP_ZERO;
      end
      default: begin
        uc.fall = STEP_IDLE;
      end
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

FILE: design/msmf_if.sv
// valid/ready channel interfaces of the sliding median filter
// depends on msmf_pkg for the payload types
`default_nettype none

// sample transaction: channel number and converter sample
interface msmf_in_if;
  logic           valid;
  logic           ready;
  msmf_pkg::chan_t channel;
  msmf_pkg::smp_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// result transaction: median of the channel window
interface msmf_out_if;
  logic          valid;
  logic          ready;
  msmf_pkg::smp_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

FILE: design/multichannel_sliding_median_filter.sv
// result: registered in median_q after the WRITE, READ, LOAD and SELECT steps that follow acceptance
// input ready only in the idle step, so no new transaction is taken until the walk over
//   the channel window through the single read port of the sample memory has ended
// reset: windows read as zero and all write pointers are zero right after reset
// a sample whose channel is out of range leaves the windows and write pointers alone and
//   yields zero through the WRITE and ZERO steps, with input ready again once the zero is loaded
`default_nettype none

module multichannel_sliding_median_filter #(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned WINDOW   = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msmf_in_if.sink     in_i,
  msmf_out_if.source  out_o
);

`include "multichannel_sliding_median_filter_macros.svh"

  localparam int unsigned DEPTH    = CHANNELS * WINDOW;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned IDX_W    = $clog2(WINDOW + 1);
  localparam int unsigned CHS_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_W_EXT = msmf_pkg::CH_W + CHS_W;

  // sequencer
  msmf_pkg::step_t  step_q, step_d;
  msmf_pkg::ucode_t uc;
  logic             take;

  // captured transaction
  msmf_pkg::chan_t ch_q;
  msmf_pkg::smp_t  smp_q;

  // per-channel write pointers, ring-full flags and window memory
  logic [PTR_W-1:0] ptr_q [CHANNELS];
  logic             full_q [CHANNELS];
  msmf_pkg::smp_t   mem [DEPTH];

  // window walk
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] ld_cnt_q, ld_cnt_d;
  msmf_pkg::smp_t   rd_data_q;
  logic             rd_vld_q;
  msmf_pkg::smp_t   elem;

  // output register
  logic           out_valid_q, out_valid_d;
  msmf_pkg::smp_t median_q;
  msmf_pkg::smp_t rank_median;
  logic           out_free;
  logic           out_load;

  logic [CH_W_EXT-1:0] ch_ext;
  logic [CHS_W-1:0]  ch_idx;
  logic              ch_ok;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0]  ptr_cur;
  logic [PTR_W-1:0]  ptr_nxt;
  logic              wr;
  logic              rd;

  // control word of the current step
  assign uc = msmf_pkg::ucode_rom(step_q);

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (uc.sel_median || uc.sel_zero) && out_free;

  // channel decode
  assign ch_ext    = {{CHS_W{1'b0}}, ch_q};
  assign ch_idx    = ch_ext[CHS_W-1:0];
  assign ch_ok     = (32'(ch_q) < CHANNELS);
  assign base_addr = ADDR_W'(ch_idx * WINDOW);
  assign ptr_cur   = ptr_q[ch_idx];
  assign ptr_nxt   = (ptr_cur == PTR_W'(WINDOW - 1)) ? '0 : ptr_cur + PTR_W'(1);
  assign wr_addr   = base_addr + ADDR_W'(ptr_cur);
  assign rd_addr   = base_addr + ADDR_W'(rd_idx_q);
  assign wr        = uc.wr_en && ch_ok;
  assign rd        = uc.rd_issue && (32'(rd_idx_q) < WINDOW);

  // jump condition
  always_comb begin
    unique case (uc.cond)
      msmf_pkg::COND_NEVER:    take = 1'b0;
      msmf_pkg::COND_ACCEPT:   take = in_i.valid;
      msmf_pkg::COND_BAD_CH:   take = !ch_ok;
      msmf_pkg::COND_LAST:     take = (ld_cnt_q == IDX_W'(WINDOW - 1));
      msmf_pkg::COND_OUT_FREE: take = out_free;
      default:                 take = 1'b0;
    endcase
  end

  assign step_d = take ? uc.jump : uc.fall;

  // walk counters
  always_comb begin
    rd_idx_d = rd_idx_q;
    ld_cnt_d = ld_cnt_q;
    if (uc.wr_en) begin
      rd_idx_d = '0;
      ld_cnt_d = '0;
    end else begin
      if (rd) begin
        rd_idx_d = rd_idx_q + IDX_W'(1);
      end
      if (uc.load) begin
        ld_cnt_d = ld_cnt_q + IDX_W'(1);
      end
    end
  end

  // output valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= msmf_pkg::STEP_IDLE;
      rd_idx_q    <= '0;
      ld_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        full_q[c] <= 1'b0;
      end
    end else begin
      step_q      <= step_d;
      rd_idx_q    <= rd_idx_d;
      ld_cnt_q    <= ld_cnt_d;
      out_valid_q <= out_valid_d;
      if (wr) begin
        ptr_q[ch_idx] <= ptr_nxt;
        if (ptr_cur == PTR_W'(WINDOW - 1)) begin
          full_q[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (in_i.valid && uc.in_ready) begin
      ch_q  <= in_i.channel;
      smp_q <= in_i.sample;
    end
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[wr_addr] <= smp_q;
    end
  end

  // a slot holds data once the ring has wrapped or the pointer has passed it
  always_ff @(posedge clk_i) begin
    if (rd) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= full_q[ch_idx] || (rd_idx_q < IDX_W'(ptr_cur));
    end
  end

  // slots never written read as zero
  assign elem = rd_vld_q ? rd_data_q : '0;

  msmf_rank #(
    .WINDOW (WINDOW)
  ) u_rank (
    .clk_i    (clk_i),
    .load_i   (uc.load),
    .idx_i    (ld_cnt_q),
    .data_i   (elem),
    .median_o (rank_median)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= uc.sel_zero ? '0 : rank_median;
    end
  end

  assign in_i.ready   = uc.in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.median = median_q;

  // checks
  `MSMF_ASSERT(a_accept_to_write, in_i.valid && in_i.ready |=> step_q == msmf_pkg::STEP_WRITE, "accepted transaction did not start a write")
  `MSMF_ASSERT(a_ptr_in_range, wr |-> 32'(ptr_cur) < WINDOW, "write pointer beyond window")
  `MSMF_ASSERT(a_load_bound, uc.load |-> 32'(ld_cnt_q) < WINDOW, "window walk ran past its end")
  `MSMF_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(step_q == msmf_pkg::STEP_SELECT || step_q == msmf_pkg::STEP_ZERO), "result raised outside a result step")

endmodule

`default_nettype wire

FILE: design/msmf_rank.sv
// rank unit: takes the window one element a cycle while load_i is high and keeps rank counts
// depends on msmf_pkg for the sample type
`default_nettype none

module msmf_rank #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [$clog2(WINDOW+1)-1:0]    idx_i,
  input  msmf_pkg::smp_t                 data_i,
  output msmf_pkg::smp_t                 median_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned MID   = WINDOW / 2;

  msmf_pkg::smp_t   x_q  [WINDOW];
  logic [CNT_W-1:0] lt_q [WINDOW];
  logic [CNT_W-1:0] le_q [WINDOW];

  logic [CNT_W-1:0] lt_new;
  logic [CNT_W-1:0] le_new;

  // counts for the incoming element against those already loaded
  always_comb begin
    lt_new = '0;
    le_new = CNT_W'(1);
    for (int i = 0; i < WINDOW; i++) begin
      if (CNT_W'(i) < idx_i) begin
        lt_new = lt_new + CNT_W'(x_q[i] < data_i);
        le_new = le_new + CNT_W'(x_q[i] <= data_i);
      end
    end
  end

  // store the new element, bump counts of the older ones
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (CNT_W'(i) < idx_i) begin
          lt_q[i] <= lt_q[i] + CNT_W'(data_i < x_q[i]);
          le_q[i] <= le_q[i] + CNT_W'(data_i <= x_q[i]);
        end else if (CNT_W'(i) == idx_i) begin
          x_q[i]  <= data_i;
          lt_q[i] <= lt_new;
          le_q[i] <= le_new;
        end
      end
    end
  end

  // element whose rank span covers the middle; equal matches carry equal values
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (lt_q[i] <= CNT_W'(MID) && CNT_W'(MID) < le_q[i]) begin
        median_o = median_o | x_q[i];
      end
    end
  end

endmodule

`default_nettype wire
